// ===== hdl/dpfr_pkg.sv =====
// Shared types and constants for the duplicated payload frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package dpfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned COUNT_W  = 5;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hFE;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'hEF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 2'd0,
		REG_END_MARKER   = 2'd1
	} cfg_reg_t;

	typedef enum logic [KIND_W-1:0] {
		EV_STORED   = 3'd0,
		EV_START    = 3'd1,
		EV_LINE_ERR = 3'd2,
		EV_REJECT   = 3'd3,
		EV_PAYLOAD  = 3'd4
	} ev_kind_t;

	// Controller to datapath.
	typedef struct packed {
		logic     clear;      // drop all stored bytes, zero the write index
		logic     store;      // write the incoming byte, advance the index
		logic     walk_init;  // restart the pair walk
		logic     rd;         // read one pair, advance the walk
		logic     wi_zero;    // zero the write index only
		logic     ld;         // load the output register
		ev_kind_t kind;
		logic     use_mem;    // payload from the registered read
		logic     use_cnt;    // report the write index
		logic     last;
	} dpfr_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic slot_free;
		logic in_err;
		logic in_start;
		logic in_end;
		logic bad;
		logic pair_last;
		logic rd_last;
	} dpfr_stat_t;

endpackage

`default_nettype wire

// ===== hdl/duplicated_payload_frame_receiver_unit.sv =====
// Top level of the duplicated payload frame receiver.
// A stored, start or line-error word is registered and shows its result in the cycle after acceptance.
// End marker: the controller walks the stored pairs through the two-port store read;
// a mismatch gives a reject word, a match gives HALF_LEN payload words, each read then loaded.
// Throughput: one word per cycle for plain bytes while the output slot is free; no input is taken during the walk.
// Reset: markers return to 0xFE / 0xEF and all store entries read as zero at once.
`timescale 1ns / 1ps
`default_nettype none

module duplicated_payload_frame_receiver_unit import dpfr_pkg::*; #(
	parameter int STORE_DEPTH = 32,
	parameter int HALF_LEN    = 15
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	input  wire logic                 line_error,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [KIND_W-1:0]         event_kind,
	output logic [BYTE_W-1:0]         payload_byte,
	output logic [COUNT_W-1:0]        received_count,
	output logic                      last,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	dpfr_cmd_t  cmd;
	dpfr_stat_t stat;

	assign cfg_ready = 1'b1;

	dpfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dpfr_datapath #(
		.STORE_DEPTH (STORE_DEPTH),
		.HALF_LEN    (HALF_LEN)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.rx_byte        (rx_byte),
		.line_error     (line_error),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.event_kind     (event_kind),
		.payload_byte   (payload_byte),
		.received_count (received_count),
		.last           (last)
	);

	a_payload_only_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind != EV_PAYLOAD) |-> (payload_byte == '0))
		else $error("payload byte set on a non-payload word");

	a_count_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == EV_STORED || event_kind == EV_START ||
		event_kind == EV_LINE_ERR) |-> (received_count == '0))
		else $error("received count set on a word that does not close a frame");

	a_not_last_only_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (event_kind == EV_PAYLOAD))
		else $error("non-final word that is not a payload byte");

	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> !in_ready)
		else $error("input accepted during the pair walk");

endmodule

`default_nettype wire

// ===== hdl/dpfr_datapath.sv =====
// Byte store, pair compare walk, marker registers and output register.
`timescale 1ns / 1ps
`default_nettype none

module dpfr_datapath import dpfr_pkg::*; #(
	parameter int STORE_DEPTH = 32,
	parameter int HALF_LEN    = 15
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dpfr_cmd_t            cmd,
	output dpfr_stat_t                stat,
	input  wire logic [BYTE_W-1:0]    rx_byte,
	input  wire logic                 line_error,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [KIND_W-1:0]         event_kind,
	output logic [BYTE_W-1:0]         payload_byte,
	output logic [COUNT_W-1:0]        received_count,
	output logic                      last
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = (HALF_LEN > 1) ? $clog2(HALF_LEN) : 1;
	localparam int unsigned C_START = HALF_LEN % STORE_DEPTH;
	localparam logic [AW-1:0] C_START_A = AW'(C_START);
	localparam logic [AW-1:0] ADDR_TOP  = AW'(STORE_DEPTH - 1);
	localparam logic [CW-1:0] IDX_LAST  = CW'(HALF_LEN - 1);

	logic [BYTE_W-1:0]      start_marker_q;
	logic [BYTE_W-1:0]      end_marker_q;
	logic [BYTE_W-1:0]      mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	logic [AW-1:0]          wi_q;
	logic [AW-1:0]          a_q;
	logic [AW-1:0]          c_q;
	logic [CW-1:0]          idx_q;
	logic [BYTE_W-1:0]      rda_s1;
	logic [BYTE_W-1:0]      rdc_s1;
	logic                   va_s1;
	logic                   vc_s1;
	logic                   pend_s1;
	logic                   last_s1;
	logic                   bad_q;
	logic                   out_valid_q;
	ev_kind_t               kind_q;
	logic [BYTE_W-1:0]      byte_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic                   last_q;
	logic [BYTE_W-1:0]      byte_a;
	logic [BYTE_W-1:0]      byte_c;
	logic [31:0]            wi_ext;
	logic [COUNT_W-1:0]     cnt5;

	// Entries never written since the last clear read as zero.
	assign byte_a = va_s1 ? rda_s1 : '0;
	assign byte_c = vc_s1 ? rdc_s1 : '0;
	assign wi_ext = 32'(wi_q);
	assign cnt5   = wi_ext[COUNT_W-1:0];

	assign stat.slot_free = !out_valid_q || out_ready;
	assign stat.in_err    = line_error;
	assign stat.in_start  = (rx_byte == start_marker_q);
	assign stat.in_end    = (rx_byte == end_marker_q);
	assign stat.bad       = bad_q;
	assign stat.pair_last = (idx_q == IDX_LAST);
	assign stat.rd_last   = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[wi_q] <= rx_byte;
		end
		if (cmd.rd) begin
			rda_s1 <= mem[a_q];
			rdc_s1 <= mem[c_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			wi_q    <= '0;
			a_q     <= '0;
			c_q     <= C_START_A;
			idx_q   <= '0;
			va_s1   <= 1'b0;
			vc_s1   <= 1'b0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			if (cmd.clear) begin
				vld_q <= '0;
				wi_q  <= '0;
			end else if (cmd.wi_zero) begin
				wi_q <= '0;
			end else if (cmd.store) begin
				vld_q[wi_q] <= 1'b1;
				wi_q        <= (wi_q == ADDR_TOP) ? '0 : wi_q + AW'(1);
			end

			pend_s1 <= cmd.rd;
			if (cmd.walk_init) begin
				a_q   <= '0;
				c_q   <= C_START_A;
				idx_q <= '0;
			end else if (cmd.rd) begin
				a_q     <= (a_q == ADDR_TOP) ? '0 : a_q + AW'(1);
				c_q     <= (c_q == ADDR_TOP) ? '0 : c_q + AW'(1);
				idx_q   <= idx_q + CW'(1);
				va_s1   <= vld_q[a_q];
				vc_s1   <= vld_q[c_q];
				last_s1 <= (idx_q == IDX_LAST);
			end

			if (cmd.walk_init) begin
				bad_q <= 1'b0;
			end else if (pend_s1 && (byte_a != byte_c)) begin
				bad_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			kind_q <= cmd.kind;
			byte_q <= cmd.use_mem ? byte_a : '0;
			cnt_q  <= cmd.use_cnt ? cnt5 : '0;
			last_q <= cmd.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_kind     = kind_q;
	assign payload_byte   = byte_q;
	assign received_count = cnt_q;
	assign last           = last_q;

endmodule

`default_nettype wire

// ===== hdl/dpfr_ctrl.sv =====
// Controller state machine: input decode, pair check walk and payload emission.
`timescale 1ns / 1ps
`default_nettype none

module dpfr_ctrl import dpfr_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dpfr_stat_t stat,
	output dpfr_cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_CHK_END,
		ST_DECIDE,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE) && stat.slot_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		cmd.kind = EV_STORED;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.last = 1'b1;
					if (stat.in_err) begin
						cmd.clear = 1'b1;
						cmd.ld    = 1'b1;
						cmd.kind  = EV_LINE_ERR;
					end else if (stat.in_start) begin
						cmd.clear = 1'b1;
						cmd.ld    = 1'b1;
						cmd.kind  = EV_START;
					end else if (stat.in_end) begin
						cmd.walk_init = 1'b1;
						state_d       = ST_CHK;
					end else begin
						cmd.store = 1'b1;
						cmd.ld    = 1'b1;
						cmd.kind  = EV_STORED;
					end
				end
			end
			ST_CHK: begin
				cmd.rd = 1'b1;
				if (stat.pair_last) begin
					state_d = ST_CHK_END;
				end
			end
			// let the final pair compare land in the mismatch flag
			ST_CHK_END: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (stat.bad) begin
					if (stat.slot_free) begin
						cmd.clear   = 1'b1;
						cmd.ld      = 1'b1;
						cmd.kind    = EV_REJECT;
						cmd.use_cnt = 1'b1;
						cmd.last    = 1'b1;
						state_d     = ST_IDLE;
					end
				end else begin
					cmd.walk_init = 1'b1;
					state_d       = ST_EMIT_RD;
				end
			end
			ST_EMIT_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (stat.slot_free) begin
					cmd.ld      = 1'b1;
					cmd.kind    = EV_PAYLOAD;
					cmd.use_mem = 1'b1;
					cmd.use_cnt = 1'b1;
					cmd.last    = stat.rd_last;
					if (stat.rd_last) begin
						cmd.wi_zero = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire
